// File: src/ir_remote_frame_packer_core_assert.svh
// Assertion helpers for the IR frame packer.
`ifndef IR_REMOTE_FRAME_PACKER_CORE_ASSERT_SVH
`define IR_REMOTE_FRAME_PACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IRFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IRFP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define IRFP_ASSERT(lbl, prop, msg)
`define IRFP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: src/irfp_pkg.sv
`default_nettype none

package irfp_pkg;

  typedef enum logic [1:0] {
    ProtoNec     = 2'd0,
    ProtoAeha    = 2'd1,
    ProtoSony    = 2'd2,
    ProtoUnknown = 2'd3
  } proto_e;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StBadPayload = 2'd1,
    StBadParam   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        is_status;
    status_e     status;
    proto_e      protocol;
    logic [10:0] send_bits;
    logic [7:0]  repeats;
  } item_t;

  // configuration register indexes
  localparam logic [1:0] CfgNecCode  = 2'd0;
  localparam logic [1:0] CfgAehaCode = 2'd1;
  localparam logic [1:0] CfgSonyCode = 2'd2;

  localparam logic [15:0] AehaMinDataBits = 16'd28;
  localparam logic [15:0] MaxAehaDataBits = 16'd1260;
  localparam logic [8:0]  TxBufferBytes   = 9'd170;
  localparam logic [8:0]  PosLimit        = 9'd511;
  localparam logic [10:0] NecBitCount     = 11'd32;
  localparam logic [10:0] AehaHeaderBits  = 11'd20;

  localparam logic [7:0]  SonyBits12 = 8'd12;
  localparam logic [7:0]  SonyBits15 = 8'd15;
  localparam logic [7:0]  SonyBits20 = 8'd20;
  localparam logic [15:0] SonyMask12 = 16'h001F;
  localparam logic [15:0] SonyMask15 = 16'h00FF;
  localparam logic [15:0] SonyMask20 = 16'h1FFF;

  function automatic logic [3:0] nibble_parity(input logic [15:0] w);
    return w[3:0] ^ w[7:4] ^ w[11:8] ^ w[15:12];
  endfunction

  function automatic item_t mk_data(input logic [7:0] data, input logic [7:0] idx,
                                    input proto_e proto);
    item_t it;
    it            = '0;
    it.data_byte  = data;
    it.byte_index = idx;
    it.status     = StOk;
    it.protocol   = proto;
    return it;
  endfunction

endpackage

`default_nettype wire

// File: src/ir_remote_frame_packer_core.sv
// IR remote frame packer: NEC / AEHA / SONY transmit buffer bytes plus a closing status.
// Results of an accepted item load the three-entry result bundle, which drains one transfer
// per cycle into the output register while out_stall_i is low. An item leaves 0..3 results;
// a new item is taken once at most one result is left in the bundle and it moves out.
// Reset (rst_ni low, asynchronous): request state and valids clear, format codes
// return to 0 / 1 / 2.
`default_nettype none
`include "ir_remote_frame_packer_core_assert.svh"

module ir_remote_frame_packer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       byte_index_o,
  output logic             is_status_o,
  output logic [1:0]       status_o,
  output logic [1:0]       protocol_o,
  output logic [10:0]      send_bits_o,
  output logic [7:0]       repeats_o
);

  logic [7:0] nec_code_q, aeha_code_q, sony_code_q;

  logic [8:0]  pos_q, pos_d;
  irfp_pkg::proto_e kind_q, kind_d;
  logic [7:0]  cust_lo_q, cust_lo_d;
  logic [10:0] dbr_q, dbr_d;
  logic [7:0]  dbe_q, dbe_d;
  logic [3:0]  carry_q, carry_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  sony_bits_q, sony_bits_d;
  logic        perr_q, perr_d;

  irfp_pkg::item_t bnd_q [3];
  irfp_pkg::item_t bnd_d [3];
  logic [1:0]      bnd_cnt_q, bnd_cnt_d;
  irfp_pkg::item_t out_q, out_d;
  logic            out_valid_q, out_valid_d;

  irfp_pkg::item_t res [3];
  irfp_pkg::item_t dat0, dat1, st_item;
  logic [1:0]      n_data, n_res;
  logic            in_acc, move;

  logic [7:0]  b;
  logic [15:0] req, req_p7;
  logic [8:0]  raw_bytes;
  logic        buf_bad;
  logic [8:0]  aeha_i;
  logic [9:0]  len;
  logic [15:0] sony_mask;
  irfp_pkg::status_e st;
  logic [10:0] bits;
  logic [7:0]  rep;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nec_code_q  <= 8'd0;
      aeha_code_q <= 8'd1;
      sony_code_q <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        irfp_pkg::CfgNecCode:  nec_code_q  <= cfg_data_i;
        irfp_pkg::CfgAehaCode: aeha_code_q <= cfg_data_i;
        irfp_pkg::CfgSonyCode: sony_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign move       = (bnd_cnt_q != 2'd0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (bnd_cnt_q > 2'd1) || ((bnd_cnt_q == 2'd1) && !move);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign b         = payload_byte_i;
  assign req       = {b, dbr_q[7:0]};
  assign req_p7    = req + 16'd7;
  assign raw_bytes = 9'(({1'b0, dbr_q} + 12'd27) >> 3);
  assign buf_bad   = raw_bytes > irfp_pkg::TxBufferBytes;
  assign aeha_i    = pos_q - 9'd5;
  assign len       = {1'b0, pos_q} + 10'd1;

  // per-byte decode and state update
  always_comb begin
    pos_d       = pos_q;
    kind_d      = kind_q;
    cust_lo_d   = cust_lo_q;
    dbr_d       = dbr_q;
    dbe_d       = dbe_q;
    carry_d     = carry_q;
    addr_d      = addr_q;
    sony_bits_d = sony_bits_q;
    perr_d      = perr_q;
    n_data      = 2'd0;
    dat0        = '0;
    dat1        = '0;
    sony_mask   = '0;

    if (pos_q == 9'd0) begin
      if (b == nec_code_q) begin
        kind_d = irfp_pkg::ProtoNec;
      end else if (b == aeha_code_q) begin
        kind_d = irfp_pkg::ProtoAeha;
      end else if (b == sony_code_q) begin
        kind_d = irfp_pkg::ProtoSony;
      end else begin
        kind_d = irfp_pkg::ProtoUnknown;
        perr_d = 1'b1;
      end
    end else begin
      case (kind_q)
        irfp_pkg::ProtoNec: begin
          if (pos_q <= 9'd3) begin
            dat0   = irfp_pkg::mk_data(b, pos_q[7:0] - 8'd1, irfp_pkg::ProtoNec);
            n_data = 2'd1;
          end
          if (pos_q == 9'd3) begin
            dat1   = irfp_pkg::mk_data(~b, 8'd3, irfp_pkg::ProtoNec);
            n_data = 2'd2;
          end
        end
        irfp_pkg::ProtoAeha: begin
          case (pos_q)
            9'd1: begin
              cust_lo_d = b;
              dat0      = irfp_pkg::mk_data(b, 8'd0, irfp_pkg::ProtoAeha);
              n_data    = 2'd1;
            end
            9'd2: begin
              dat0    = irfp_pkg::mk_data(b, 8'd1, irfp_pkg::ProtoAeha);
              n_data  = 2'd1;
              carry_d = irfp_pkg::nibble_parity({b, cust_lo_q});
            end
            9'd3: dbr_d = {3'b000, b};
            9'd4: begin
              if (req < irfp_pkg::AehaMinDataBits || req > irfp_pkg::MaxAehaDataBits) begin
                perr_d = 1'b1;
              end else begin
                dbr_d = req[10:0];
                dbe_d = req_p7[10:3];
              end
            end
            default: begin
              if (!perr_q && !buf_bad && (aeha_i < {1'b0, dbe_q})) begin
                dat0    = irfp_pkg::mk_data({b[3:0], carry_q}, aeha_i[7:0] + 8'd2,
                                            irfp_pkg::ProtoAeha);
                n_data  = 2'd1;
                carry_d = b[7:4];
                // trailing nibble gets a byte of its own when the frame needs it
                if ((({1'b0, aeha_i} + 10'd1) == {2'b00, dbe_q}) &&
                    (raw_bytes >= ({1'b0, dbe_q} + 9'd3))) begin
                  dat1   = irfp_pkg::mk_data({4'h0, b[7:4]}, aeha_i[7:0] + 8'd3,
                                             irfp_pkg::ProtoAeha);
                  n_data = 2'd2;
                end
              end
            end
          endcase
        end
        irfp_pkg::ProtoSony: begin
          case (pos_q)
            9'd1: addr_d = {8'h00, b};
            9'd2: begin
              addr_d = {b, addr_q[7:0]};
              dat0   = irfp_pkg::mk_data(addr_d[8:1], 8'd1, irfp_pkg::ProtoSony);
              dat1   = irfp_pkg::mk_data({1'b0, addr_d[15:9]}, 8'd2, irfp_pkg::ProtoSony);
              n_data = 2'd2;
            end
            9'd3: begin
              dat0   = irfp_pkg::mk_data({addr_q[0], b[6:0]}, 8'd0, irfp_pkg::ProtoSony);
              n_data = 2'd1;
            end
            9'd4: begin
              sony_bits_d = b;
              case (b)
                irfp_pkg::SonyBits12: sony_mask = irfp_pkg::SonyMask12;
                irfp_pkg::SonyBits15: sony_mask = irfp_pkg::SonyMask15;
                irfp_pkg::SonyBits20: sony_mask = irfp_pkg::SonyMask20;
                default:              perr_d    = 1'b1;
              endcase
              if ((sony_mask != 16'h0000) && ((addr_q & ~sony_mask) != 16'h0000)) begin
                perr_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // closing status
    st   = irfp_pkg::StOk;
    bits = '0;
    rep  = '0;
    case (kind_d)
      irfp_pkg::ProtoNec: begin
        if ((len != 10'd5) || (b == 8'd0)) st = irfp_pkg::StBadPayload;
        else bits = irfp_pkg::NecBitCount;
      end
      irfp_pkg::ProtoAeha: begin
        if (len < 10'd6) st = irfp_pkg::StBadPayload;
        else if (perr_q) st = irfp_pkg::StBadParam;
        else if (len != ({2'b00, dbe_q} + 10'd6)) st = irfp_pkg::StBadPayload;
        else if ((b == 8'd0) || buf_bad) st = irfp_pkg::StBadParam;
        else bits = dbr_q + irfp_pkg::AehaHeaderBits;
      end
      irfp_pkg::ProtoSony: begin
        if (len != 10'd6) st = irfp_pkg::StBadPayload;
        else if (perr_q) st = irfp_pkg::StBadParam;
        else bits = {3'b000, sony_bits_q};
      end
      default: st = irfp_pkg::StBadParam;
    endcase
    if (st == irfp_pkg::StOk) rep = b;
    else bits = '0;

    st_item           = '0;
    st_item.is_status = 1'b1;
    st_item.status    = st;
    st_item.protocol  = kind_d;
    st_item.send_bits = bits;
    st_item.repeats   = rep;

    res[0] = dat0;
    res[1] = dat1;
    res[2] = '0;
    n_res  = n_data;

    if (last_byte_i) begin
      case (n_data)
        2'd0:    res[0] = st_item;
        2'd1:    res[1] = st_item;
        default: res[2] = st_item;
      endcase
      n_res       = n_data + 2'd1;
      pos_d       = '0;
      kind_d      = irfp_pkg::ProtoNec;
      cust_lo_d   = '0;
      dbr_d       = '0;
      dbe_d       = '0;
      carry_d     = '0;
      addr_d      = '0;
      sony_bits_d = '0;
      perr_d      = 1'b0;
    end else begin
      pos_d = (pos_q < irfp_pkg::PosLimit) ? pos_q + 9'd1 : irfp_pkg::PosLimit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      kind_q      <= irfp_pkg::ProtoNec;
      cust_lo_q   <= '0;
      dbr_q       <= '0;
      dbe_q       <= '0;
      carry_q     <= '0;
      addr_q      <= '0;
      sony_bits_q <= '0;
      perr_q      <= 1'b0;
    end else if (in_acc) begin
      pos_q       <= pos_d;
      kind_q      <= kind_d;
      cust_lo_q   <= cust_lo_d;
      dbr_q       <= dbr_d;
      dbe_q       <= dbe_d;
      carry_q     <= carry_d;
      addr_q      <= addr_d;
      sony_bits_q <= sony_bits_d;
      perr_q      <= perr_d;
    end
  end

  // result bundle: load on accept, advance one entry per move
  always_comb begin
    bnd_d       = bnd_q;
    bnd_cnt_d   = bnd_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (move) begin
      out_d       = bnd_q[0];
      out_valid_d = 1'b1;
      bnd_d[0]    = bnd_q[1];
      bnd_d[1]    = bnd_q[2];
      bnd_cnt_d   = bnd_cnt_q - 2'd1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      bnd_d     = res;
      bnd_cnt_d = n_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bnd_cnt_q   <= bnd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bnd_q <= bnd_d;
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_q.data_byte;
  assign byte_index_o = out_q.byte_index;
  assign is_status_o  = out_q.is_status;
  assign status_o     = out_q.status;
  assign protocol_o   = out_q.protocol;
  assign send_bits_o  = out_q.send_bits;
  assign repeats_o    = out_q.repeats;

  `IRFP_ASSERT(a_status_no_data, (out_valid_q && out_q.is_status |-> out_q.data_byte == 8'd0 && out_q.byte_index == 8'd0), "status transfer carries buffer data")
  `IRFP_ASSERT(a_error_no_counts, (out_valid_q && out_q.is_status && out_q.status != irfp_pkg::StOk |-> out_q.send_bits == 11'd0 && out_q.repeats == 8'd0), "failed request reports counts")
  `IRFP_ASSERT_NEXT(a_last_clears, in_acc && last_byte_i, (pos_q == 9'd0 && !perr_q), "request state not cleared after last byte")
  `IRFP_ASSERT_NEXT(a_move_fills_out, move, out_valid_q, "bundle entry lost on its way to the output")

endmodule

`default_nettype wire

// File: verif/ir_remote_frame_packer_core_tb.sv
`default_nettype none

module ir_remote_frame_packer_core_tb;

  localparam int unsigned CycleLimit = 400000;

  class tx_buffer_scoreboard;
    irfp_pkg::item_t pending_tx_items[$];
    int unsigned errors;
    int unsigned items_checked;
    int unsigned status_checked;
    logic [7:0] nec_code, aeha_code, sony_code;

    // request state
    logic [8:0]        pos;
    irfp_pkg::proto_e  kind;
    logic [15:0]       customer;
    logic [10:0]       data_bits;
    logic [7:0]        data_bytes;
    logic [3:0]        carry;
    logic [15:0]       addr;
    logic [7:0]        sony_len;
    irfp_pkg::status_e pend;

    function new();
      nec_code  = 8'd0;
      aeha_code = 8'd1;
      sony_code = 8'd2;
      errors = 0;
      items_checked = 0;
      status_checked = 0;
      clear_request();
    endfunction

    function void clear_request();
      pos        = '0;
      kind       = irfp_pkg::ProtoNec;
      customer   = '0;
      data_bits  = '0;
      data_bytes = '0;
      carry      = '0;
      addr       = '0;
      sony_len   = '0;
      pend       = irfp_pkg::StOk;
    endfunction

    function int unsigned aeha_bytes();
      return (irfp_pkg::AehaHeaderBits + data_bits + 7) / 8;
    endfunction

    function bit aeha_oversized();
      return aeha_bytes() > irfp_pkg::TxBufferBytes;
    endfunction

    function void push_data(logic [7:0] d, int unsigned idx);
      irfp_pkg::item_t it;
      it            = '0;
      it.data_byte  = d;
      it.byte_index = idx[7:0];
      it.status     = irfp_pkg::StOk;
      it.protocol   = kind;
      pending_tx_items.push_back(it);
    endfunction

    function int unsigned outstanding();
      return pending_tx_items.size();
    endfunction

    function void note_payload_byte(logic [7:0] b, logic last);
      int unsigned p, len, i;
      logic [15:0] req, mask;
      irfp_pkg::status_e st;
      logic [10:0] bits;
      logic [7:0] rep;
      irfp_pkg::item_t it;
      p    = pos;
      len  = p + 1;
      st   = irfp_pkg::StOk;
      bits = '0;
      rep  = '0;
      if (p == 0) begin
        if (b == nec_code) kind = irfp_pkg::ProtoNec;
        else if (b == aeha_code) kind = irfp_pkg::ProtoAeha;
        else if (b == sony_code) kind = irfp_pkg::ProtoSony;
        else begin
          kind = irfp_pkg::ProtoUnknown;
          pend = irfp_pkg::StBadParam;
        end
      end else begin
        case (kind)
          irfp_pkg::ProtoNec: begin
            if (p <= 3) push_data(b, p - 1);
            if (p == 3) push_data(~b, 3);
          end
          irfp_pkg::ProtoAeha: begin
            if (p == 1) begin
              customer = {8'h00, b};
              push_data(b, 0);
            end else if (p == 2) begin
              customer[15:8] = b;
              push_data(b, 1);
              carry = customer[3:0] ^ customer[7:4] ^ customer[11:8] ^ customer[15:12];
            end else if (p == 3) begin
              data_bits = {3'b000, b};
            end else if (p == 4) begin
              req = {b, data_bits[7:0]};
              if (req < irfp_pkg::AehaMinDataBits || req > irfp_pkg::MaxAehaDataBits) begin
                pend = irfp_pkg::StBadParam;
              end else begin
                data_bits  = req[10:0];
                data_bytes = 8'((req + 7) / 8);
              end
            end else if (pend == irfp_pkg::StOk && !aeha_oversized()) begin
              i = p - 5;
              if (i < data_bytes) begin
                push_data({b[3:0], carry}, i + 2);
                carry = b[7:4];
                // trailing nibble gets a byte of its own when the frame needs it
                if (i + 1 == data_bytes && aeha_bytes() >= 3 + data_bytes)
                  push_data({4'h0, carry}, i + 3);
              end
            end
          end
          irfp_pkg::ProtoSony: begin
            if (p == 1) begin
              addr = {8'h00, b};
            end else if (p == 2) begin
              addr[15:8] = b;
              push_data(addr[8:1], 1);
              push_data({1'b0, addr[15:9]}, 2);
            end else if (p == 3) begin
              push_data({addr[0], b[6:0]}, 0);
            end else if (p == 4) begin
              sony_len = b;
              case (b)
                irfp_pkg::SonyBits12: mask = irfp_pkg::SonyMask12;
                irfp_pkg::SonyBits15: mask = irfp_pkg::SonyMask15;
                irfp_pkg::SonyBits20: mask = irfp_pkg::SonyMask20;
                default: begin
                  mask = '0;
                  pend = irfp_pkg::StBadParam;
                end
              endcase
              if (mask != 0 && (addr & ~mask) != 0) pend = irfp_pkg::StBadParam;
            end
          end
          default: ;
        endcase
      end

      if (!last) begin
        pos = (p < irfp_pkg::PosLimit) ? 9'(p + 1) : irfp_pkg::PosLimit;
        return;
      end

      case (kind)
        irfp_pkg::ProtoNec: begin
          if (len != 5 || b == 0) st = irfp_pkg::StBadPayload;
          else bits = irfp_pkg::NecBitCount;
        end
        irfp_pkg::ProtoAeha: begin
          if (len < 6) st = irfp_pkg::StBadPayload;
          else if (pend != irfp_pkg::StOk) st = irfp_pkg::StBadParam;
          else if (len != 6 + data_bytes) st = irfp_pkg::StBadPayload;
          else if (b == 0 || aeha_oversized()) st = irfp_pkg::StBadParam;
          else bits = irfp_pkg::AehaHeaderBits + data_bits;
        end
        irfp_pkg::ProtoSony: begin
          if (len != 6) st = irfp_pkg::StBadPayload;
          else if (pend != irfp_pkg::StOk) st = irfp_pkg::StBadParam;
          else bits = {3'b000, sony_len};
        end
        default: st = irfp_pkg::StBadParam;
      endcase
      if (st == irfp_pkg::StOk) rep = b;
      else bits = '0;
      it           = '0;
      it.is_status = 1'b1;
      it.status    = st;
      it.protocol  = kind;
      it.send_bits = bits;
      it.repeats   = rep;
      pending_tx_items.push_back(it);
      clear_request();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_tx_item(irfp_pkg::item_t got);
      irfp_pkg::item_t want;
      if (pending_tx_items.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual data %0d index %0d status-item %0d",
                 $time, got.data_byte, got.byte_index, got.is_status);
        errors++;
        return;
      end
      want = pending_tx_items.pop_front();
      items_checked++;
      if (want.is_status) status_checked++;
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("is_status", want.is_status, got.is_status);
      compare_field("status", int'(want.status), int'(got.status));
      compare_field("protocol", int'(want.protocol), int'(got.protocol));
      compare_field("send_bits", want.send_bits, got.send_bits);
      compare_field("repeats", want.repeats, got.repeats);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  payload_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  data_byte_o;
  logic [7:0]  byte_index_o;
  logic        is_status_o;
  logic [1:0]  status_o;
  logic [1:0]  protocol_o;
  logic [10:0] send_bits_o;
  logic [7:0]  repeats_o;

  ir_remote_frame_packer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .payload_byte_i (payload_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .is_status_o    (is_status_o),
    .status_o       (status_o),
    .protocol_o     (protocol_o),
    .send_bits_o    (send_bits_o),
    .repeats_o      (repeats_o)
  );

  always #4 clk_i = ~clk_i;

  tx_buffer_scoreboard board;
  logic [7:0]  req_q[$];
  bit          sender_idles;
  int          stall_mode;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  int unsigned requests_sent;
  int unsigned settings_used;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // stall is stable from one rising edge to the next, so sample at the falling edge
  always @(negedge clk_i) begin : result_mon
    irfp_pkg::item_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got            = '0;
      got.data_byte  = data_byte_o;
      got.byte_index = byte_index_o;
      got.is_status  = is_status_o;
      got.status     = irfp_pkg::status_e'(status_o);
      got.protocol   = irfp_pkg::proto_e'(protocol_o);
      got.send_bits  = send_bits_o;
      got.repeats    = repeats_o;
      board.check_tx_item(got);
    end
  end

  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return 0;
      1: begin
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
      end
      default: begin
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(8, 30);
      end
    endcase
  endfunction

  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk_i);
      n = pick_gap(stall_mode);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int n;
    n = sender_idles ? pick_gap(1) : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    payload_byte_i <= b;
    last_byte_i    <= last;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    board.note_payload_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_request();
    foreach (req_q[k]) send_byte(req_q[k], k == req_q.size() - 1);
    requests_sent++;
  endtask

  // hold off until every expected result has come, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_codes(logic [7:0] nec, logic [7:0] aeha, logic [7:0] sony);
    write_reg(irfp_pkg::CfgNecCode, nec);
    write_reg(irfp_pkg::CfgAehaCode, aeha);
    write_reg(irfp_pkg::CfgSonyCode, sony);
    cfg_we_i <= 1'b0;
    board.nec_code  = nec;
    board.aeha_code = aeha;
    board.sony_code = sony;
    settings_used++;
  endtask

  task automatic build_aeha(logic [15:0] bits, int data_n);
    req_q.push_back(board.aeha_code);
    req_q.push_back(rand_byte());
    req_q.push_back(rand_byte());
    req_q.push_back(bits[7:0]);
    req_q.push_back(bits[15:8]);
    repeat (data_n) req_q.push_back(rand_byte());
    req_q.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic build_sony(bit bad);
    logic [7:0]  len;
    logic [15:0] mask, addr;
    case ($urandom_range(0, 2))
      0: begin len = irfp_pkg::SonyBits12; mask = irfp_pkg::SonyMask12; end
      1: begin len = irfp_pkg::SonyBits15; mask = irfp_pkg::SonyMask15; end
      default: begin len = irfp_pkg::SonyBits20; mask = irfp_pkg::SonyMask20; end
    endcase
    addr = 16'($urandom_range(0, mask));
    if (bad) begin
      if ($urandom_range(0, 1) == 0) begin
        do len = rand_byte();
        while (len == irfp_pkg::SonyBits12 || len == irfp_pkg::SonyBits15 ||
               len == irfp_pkg::SonyBits20);
      end else begin
        addr = 16'($urandom_range(mask + 1, 65535));
      end
    end
    req_q.push_back(board.sony_code);
    req_q.push_back(addr[7:0]);
    req_q.push_back(addr[15:8]);
    req_q.push_back(rand_byte());
    req_q.push_back(len);
    req_q.push_back(rand_byte());
  endtask

  // mostly well-formed requests with random content; the rest broken or noise
  task automatic build_random_request();
    int r, variant, cut;
    logic [15:0] bits;
    logic [7:0] first;
    req_q.delete();
    r = $urandom_range(0, 99);
    variant = $urandom_range(0, 9);
    if (r < 25) begin
      req_q.push_back(board.nec_code);
      repeat (3) req_q.push_back(rand_byte());
      req_q.push_back((variant == 6 || variant == 7) ? 8'h00 : 8'($urandom_range(1, 255)));
    end else if (r < 60) begin
      if (variant == 6) begin
        bits = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 27))
                                           : 16'($urandom_range(1261, 65535));
        build_aeha(bits, $urandom_range(0, 4));
      end else begin
        bits = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(65, 400))
                                           : 16'($urandom_range(28, 72));
        build_aeha(bits, (bits + 7) / 8);
      end
      if (variant == 7) req_q[req_q.size() - 1] = 8'h00;
    end else if (r < 88) begin
      build_sony(variant == 6);
    end else begin
      do first = rand_byte();
      while (first == board.nec_code || first == board.aeha_code || first == board.sony_code);
      req_q.push_back(first);
      repeat ($urandom_range(0, 6)) req_q.push_back(rand_byte());
      return;
    end
    if (variant == 8 && req_q.size() > 1) begin
      cut = $urandom_range(1, req_q.size() - 1);
      req_q = req_q[0:cut-1];
    end
    if (variant == 9)
      repeat ($urandom_range(1, 3)) req_q.insert(req_q.size() - 1, rand_byte());
  endtask

  initial begin : stimulus
    int phase, target;
    int unsigned phase_start;
    logic [7:0] a, b, c;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = irfp_pkg::CfgNecCode;
    cfg_data_i     = 8'h00;
    in_valid_i     = 1'b0;
    payload_byte_i = 8'h00;
    last_byte_i    = 1'b0;
    out_stall_i    = 1'b0;
    sender_idles   = 1'b0;
    stall_mode     = 0;
    cycle_cnt      = 0;
    bytes_sent     = 0;
    requests_sent  = 0;
    settings_used  = 1;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset codes, back-to-back transfers
    req_q = '{board.nec_code, 8'h00, 8'hFF, 8'hA5, 8'hFF};
    send_request();
    req_q = '{8'hFF};
    send_request();
    req_q = '{board.aeha_code, 8'h34, 8'h12, 8'd28, 8'h00, 8'h5C, 8'hA3, 8'h0F, 8'hF7, 8'h01};
    send_request();
    req_q = '{board.sony_code, 8'hFF, 8'h1F, 8'h80, irfp_pkg::SonyBits20, 8'h00};
    send_request();
    drain();

    for (phase = 1; phase <= 8; phase++) begin
      case (phase)
        1: set_codes(8'hFF, 8'h00, 8'h80);
        2: set_codes(8'h5A, 8'h5A, 8'h5A);
        3: set_codes(8'hC4, 8'h33, 8'h33);
        default: begin
          a = rand_byte();
          do b = rand_byte(); while (b == a);
          do c = rand_byte(); while (c == a || c == b);
          set_codes(a, b, c);
        end
      endcase
      sender_idles = (phase % 3) != 0;
      stall_mode   = phase % 3;
      if (phase == 1) begin
        // largest AEHA frame
        req_q.delete();
        build_aeha(irfp_pkg::MaxAehaDataBits, (irfp_pkg::MaxAehaDataBits + 7) / 8);
        send_request();
      end
      target = (phase == 2 || phase == 3) ? 10 : 14;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < target) begin
        build_random_request();
        send_request();
        if ($urandom_range(0, 9) == 0) drain();
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Sent %0d payload bytes in %0d requests under %0d format-code settings.",
             bytes_sent, requests_sent, settings_used);
    $display("Checked %0d results, %0d of them status items.",
             board.items_checked, board.status_checked);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
